// ===== rtl/bvm_pkg.sv =====
// Shared types, constants and codes for the battery voltage monitor.
`default_nettype none

package bvm_pkg;

   localparam int SAMPLES_DEFAULT = 8;
   localparam int SAMPLE_W        = 12;
   localparam int MV_W            = 16;
   localparam int COUNT_W         = 5;
   localparam int PCT_W           = 8;
   localparam int DIV_W           = 32;
   localparam int QUEUE_DEPTH     = 2;
   localparam int CSR_ADDR_W      = 3;
   localparam int REQ_DATA_W      = 24;
   localparam int RSP_DATA_W      = 32;

   // Fallback conversion raw * 3300 / 4095
   localparam logic [23:0]      FALLBACK_MUL = 24'd3300;
   localparam logic [12:0]      FALLBACK_DIV = 13'd4095;
   localparam logic [PCT_W-1:0] PCT_FULL     = 8'd100;
   localparam logic [PCT_W-1:0] PCT_NONE     = 8'hFF;
   localparam logic [PCT_W-1:0] PCT_EMPTY    = 8'd0;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_ENABLED,
      CSR_SCALE_NUM,
      CSR_SCALE_DEN,
      CSR_MIN_VALID_MV,
      CSR_MAX_VALID_MV,
      CSR_EMPTY_MV,
      CSR_FULL_MV
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_OK,
      ST_DISABLED,
      ST_NO_SAMPLES,
      ST_BAD
   } status_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_CHECK,
      BK_AVG_WAIT,
      BK_SCALE,
      BK_MV_START,
      BK_MV_WAIT,
      BK_WINDOW,
      BK_PCT_START,
      BK_PCT_WAIT,
      BK_EMIT
   } back_state_type;

   typedef struct packed {
      logic            enabled;
      logic [MV_W-1:0] scale_num;
      logic [MV_W-1:0] scale_den;
      logic [MV_W-1:0] min_valid_mv;
      logic [MV_W-1:0] max_valid_mv;
      logic [MV_W-1:0] empty_mv;
      logic [MV_W-1:0] full_mv;
   } cfg_type;

   // One finished burst, handed from front to back
   typedef struct packed {
      logic [MV_W-1:0]    sum;
      logic [COUNT_W-1:0] count;
   } job_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [MV_W-1:0]  divisor;
   } div_req_type;

endpackage

`default_nettype wire

// ===== rtl/bvm_front.sv =====
// Front end: takes samples, converts fallbacks, accumulates a burst, pushes the total.
`default_nettype none

module bvm_front
   import bvm_pkg::*;
#(
   parameter int SAMPLES_PER_READING = SAMPLES_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic                  req_tuser,
   input  wire logic                  queue_full,
   output logic                       push,
   output job_type                    push_job
);

   localparam int POS_W = (SAMPLES_PER_READING > 1) ? $clog2(SAMPLES_PER_READING) : 1;
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(SAMPLES_PER_READING - 1);

   logic [MV_W-1:0]     sum_ff, sum_in, sum_next;
   logic [COUNT_W-1:0]  count_ff, count_in, count_next;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [SAMPLE_W-1:0] sample_mv, raw_code, fb_est, fb_mv, pin;
   logic [23:0]         fb_prod;
   logic [12:0]         fb_rem;
   logic                last, accept, take;

   assign sample_mv = req_tdata[SAMPLE_W-1:0];
   assign raw_code  = req_tdata[2*SAMPLE_W-1:SAMPLE_W];
   assign last      = (pos_ff == POS_LAST);

   // The burst's last sample needs queue room for its total
   assign req_tready = !queue_full || !last;
   assign accept     = req_tvalid && req_tready;

   // Divide by 4095: the estimate p>>12 is low by at most one
   always_comb begin
      fb_prod = {12'd0, raw_code} * FALLBACK_MUL;
      fb_est  = fb_prod[23:12];
      fb_rem  = {1'b0, fb_prod[11:0]} + {1'b0, fb_est};
      fb_mv   = (fb_rem >= FALLBACK_DIV) ? fb_est + 12'd1 : fb_est;
   end

   always_comb begin
      if (sample_mv != '0) begin
         pin = sample_mv;
      end else if (req_tuser) begin
         pin = '0;
      end else begin
         pin = fb_mv;
      end
      take       = (pin != '0);
      sum_next   = sum_ff + MV_W'(pin);
      count_next = count_ff + COUNT_W'(take);
   end

   always_comb begin
      sum_in   = sum_ff;
      count_in = count_ff;
      pos_in   = pos_ff;
      if (accept) begin
         if (last) begin
            sum_in   = '0;
            count_in = '0;
            pos_in   = '0;
         end else begin
            sum_in   = sum_next;
            count_in = count_next;
            pos_in   = pos_ff + POS_W'(1);
         end
      end
   end

   assign push           = accept && last;
   assign push_job.sum   = sum_next;
   assign push_job.count = count_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         count_ff <= '0;
         pos_ff   <= '0;
      end else begin
         sum_ff   <= sum_in;
         count_ff <= count_in;
         pos_ff   <= pos_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/bvm_queue.sv =====
// Short queue of burst totals between front and back.
`default_nettype none

module bvm_queue
   import bvm_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  job_type      push_job,
   input  wire logic    pop,
   output job_type      head_job,
   output logic         full,
   output logic         empty
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

   job_type           slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic              do_push, do_pop;

   assign full     = (fill_ff == CNT_W'(QUEUE_DEPTH));
   assign empty    = (fill_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_job = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/bvm_div.sv =====
// Shared restoring divider, two quotient bits per cycle.
`default_nettype none

module bvm_div
   import bvm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  div_req_type      req,
   output logic             done,
   output logic [DIV_W-1:0] quotient
);

   localparam int STEPS  = DIV_W / 2;
   localparam int STEP_W = $clog2(STEPS);
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(STEPS - 1);

   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic [MV_W-1:0]   rem_ff, rem_in, divisor_ff, divisor_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic [MV_W:0]     trial_a, trial_b;
   logic [MV_W-1:0]   rem_a;
   logic              bit_a, bit_b;

   // The full quotient shows already in the done cycle and holds until the next start
   assign done     = busy_ff && (step_ff == STEP_LAST);
   assign quotient = quo_in;

   always_comb begin
      trial_a = {rem_ff, quo_ff[DIV_W-1]};
      bit_a   = (trial_a >= {1'b0, divisor_ff});
      rem_a   = bit_a ? MV_W'(trial_a - {1'b0, divisor_ff}) : trial_a[MV_W-1:0];
      trial_b = {rem_a, quo_ff[DIV_W-2]};
      bit_b   = (trial_b >= {1'b0, divisor_ff});
   end

   always_comb begin
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      step_in    = step_ff;
      busy_in    = busy_ff;
      if (req.start) begin
         quo_in     = req.dividend;
         rem_in     = '0;
         divisor_in = req.divisor;
         step_in    = '0;
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[DIV_W-3:0], bit_a, bit_b};
         rem_in  = bit_b ? MV_W'(trial_b - {1'b0, divisor_ff}) : trial_b[MV_W-1:0];
         step_in = step_ff + STEP_W'(1);
         busy_in = !done;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/bvm_back.sv =====
// Back end: average, scale, window check and percent per burst, with the result register.
`default_nettype none

module bvm_back
   import bvm_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  cfg_type         cfg,
   input  job_type         head_job,
   input  wire logic       queue_empty,
   output logic            pop,
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output status_type      rsp_status,
   output logic [MV_W-1:0] rsp_battery_mv,
   output logic [PCT_W-1:0] rsp_percent
);

   back_state_type   state_ff, state_in;
   job_type          job_ff, job_in;
   status_type       status_ff, status_in;
   logic [MV_W-1:0]  batt_ff, batt_in;
   logic [PCT_W-1:0] pct_ff, pct_in;
   logic [DIV_W-1:0] prod_ff, prod_in;

   logic             out_valid_ff, out_valid_in;
   status_type       out_status_ff, out_status_in;
   logic [MV_W-1:0]  out_batt_ff, out_batt_in;
   logic [PCT_W-1:0] out_pct_ff, out_pct_in;

   div_req_type      div_req;
   logic             div_done;
   logic [DIV_W-1:0] div_quo;

   logic             check_go, win_bad, pct_none, pct_zero, pct_top, pct_direct, out_free;
   status_type       check_status;
   logic [MV_W-1:0]  mv16, span;
   logic [PCT_W-1:0] pct_direct_val;

   bvm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .req      (div_req),
      .done     (div_done),
      .quotient (div_quo)
   );

   // Decisions
   always_comb begin
      if (!cfg.enabled) begin
         check_status = ST_DISABLED;
      end else if (job_ff.count == '0) begin
         check_status = ST_NO_SAMPLES;
      end else if (cfg.scale_den == '0) begin
         check_status = ST_BAD;
      end else begin
         check_status = ST_OK;
      end
      check_go = (check_status == ST_OK);

      mv16     = div_quo[MV_W-1:0];
      span     = cfg.full_mv - cfg.empty_mv;
      win_bad  = (div_quo < DIV_W'(cfg.min_valid_mv)) || (div_quo > DIV_W'(cfg.max_valid_mv));
      pct_none = (cfg.full_mv <= cfg.empty_mv);
      pct_zero = (mv16 <= cfg.empty_mv);
      pct_top  = (mv16 >= cfg.full_mv);
      pct_direct = pct_none || pct_zero || pct_top;
      if (pct_none) begin
         pct_direct_val = PCT_NONE;
      end else if (pct_zero) begin
         pct_direct_val = PCT_EMPTY;
      end else begin
         pct_direct_val = PCT_FULL;
      end

      out_free = !out_valid_ff || rsp_tready;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE:      if (!queue_empty) state_in = BK_CHECK;
         BK_CHECK:     state_in = check_go ? BK_AVG_WAIT : BK_EMIT;
         BK_AVG_WAIT:  if (div_done) state_in = BK_SCALE;
         BK_SCALE:     state_in = BK_MV_START;
         BK_MV_START:  state_in = BK_MV_WAIT;
         BK_MV_WAIT:   if (div_done) state_in = BK_WINDOW;
         BK_WINDOW:    state_in = (win_bad || pct_direct) ? BK_EMIT : BK_PCT_START;
         BK_PCT_START: state_in = BK_PCT_WAIT;
         BK_PCT_WAIT:  if (div_done) state_in = BK_EMIT;
         BK_EMIT:      if (out_free) state_in = BK_IDLE;
         default:      state_in = BK_IDLE;
      endcase
   end

   // Control outputs
   always_comb begin
      pop              = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = prod_ff;
      div_req.divisor  = cfg.scale_den;
      case (state_ff)
         BK_IDLE: begin
            pop = !queue_empty;
         end
         BK_CHECK: begin
            div_req.start    = check_go;
            div_req.dividend = DIV_W'(job_ff.sum);
            div_req.divisor  = MV_W'(job_ff.count);
         end
         BK_MV_START: begin
            div_req.start = 1'b1;
         end
         BK_PCT_START: begin
            div_req.start   = 1'b1;
            div_req.divisor = span;
         end
         default: begin
            pop = 1'b0;
         end
      endcase
   end

   // Datapath
   always_comb begin
      job_in        = job_ff;
      status_in     = status_ff;
      batt_in       = batt_ff;
      pct_in        = pct_ff;
      prod_in       = prod_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_status_in = out_status_ff;
      out_batt_in   = out_batt_ff;
      out_pct_in    = out_pct_ff;
      case (state_ff)
         BK_IDLE: begin
            job_in = head_job;
         end
         BK_CHECK: begin
            status_in = check_status;
            batt_in   = '0;
            pct_in    = PCT_NONE;
         end
         BK_SCALE: begin
            prod_in = {16'd0, mv16} * {16'd0, cfg.scale_num};
         end
         BK_WINDOW: begin
            if (win_bad) begin
               status_in = ST_BAD;
            end else begin
               status_in = ST_OK;
               batt_in   = mv16;
               pct_in    = pct_direct_val;
               prod_in   = {16'd0, mv16 - cfg.empty_mv} * DIV_W'(PCT_FULL);
            end
         end
         BK_PCT_WAIT: begin
            if (div_done) pct_in = div_quo[PCT_W-1:0];
         end
         BK_EMIT: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_status_in = status_ff;
               out_batt_in   = batt_ff;
               out_pct_in    = pct_ff;
            end
         end
         default: begin
            job_in = job_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      job_ff        <= job_in;
      status_ff     <= status_in;
      batt_ff       <= batt_in;
      pct_ff        <= pct_in;
      prod_ff       <= prod_in;
      out_status_ff <= out_status_in;
      out_batt_ff   <= out_batt_in;
      out_pct_ff    <= out_pct_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_tvalid     = out_valid_ff;
   assign rsp_status     = out_status_ff;
   assign rsp_battery_mv = out_batt_ff;
   assign rsp_percent    = out_pct_ff;

endmodule

`default_nettype wire

// ===== rtl/battery_voltage_monitor_core.sv =====
// Top level of the battery voltage monitor: registers, front, queue and back.
//
// Usage: converter samples enter on the req_ stream, one per transfer. Every
// SAMPLES_PER_READING samples form a burst; the front end sums the positive
// samples (falling back to raw_code*3300/4095 when sample_mv is zero, skipping
// the sample when the raw read also failed) and counts them. At the last sample
// of a burst it pushes the total into a two-entry queue. The back end averages,
// scales by scale_num/scale_den, checks the validity window and maps a percent,
// then places one reading on the rsp_ stream. Other samples produce no transfer.
// Throughput: one sample per cycle while the queue has room. The back end runs
// its three 32-bit divisions (average, scale, percent) one after another on the
// shared divider at two quotient bits per cycle; it skips the percent division
// when the percent needs no division or the reading leaves the window, and runs
// none for a disabled, empty or zero-divisor reading; it then emits the reading.
// Reset clears the burst, the queue, the back-end sequencer and the result
// valid flag, and loads the register defaults. While the receiver stalls, the
// result holds in its register, the back end waits with the next reading, and
// the front keeps taking samples until the queue is full at a burst end.
// The user must write registers through csr_ only while the block is idle; not enforced.
`default_nettype none

module battery_voltage_monitor_core
   import bvm_pkg::*;
#(
   parameter int SAMPLES_PER_READING = SAMPLES_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // sample stream
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,   // sample_mv[11:0], raw_code[23:12]
   input  wire logic                  req_tuser,   // raw_failed
   // reading stream
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,   // status[1:0], battery_mv[17:2],
                                                   // percent[25:18], zero fill
   // register writes
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [MV_W-1:0]       csr_wdata
);

   cfg_type          cfg_ff, cfg_in;
   job_type          push_job, head_job;
   logic             push, pop, queue_full, queue_empty;
   status_type       rsp_status;
   logic [MV_W-1:0]  rsp_battery_mv;
   logic [PCT_W-1:0] rsp_percent;

   // Register file; writes to unused indexes drop
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_ENABLED:      cfg_in.enabled      = csr_wdata[0];
            CSR_SCALE_NUM:    cfg_in.scale_num    = csr_wdata;
            CSR_SCALE_DEN:    cfg_in.scale_den    = csr_wdata;
            CSR_MIN_VALID_MV: cfg_in.min_valid_mv = csr_wdata;
            CSR_MAX_VALID_MV: cfg_in.max_valid_mv = csr_wdata;
            CSR_EMPTY_MV:     cfg_in.empty_mv     = csr_wdata;
            CSR_FULL_MV:      cfg_in.full_mv      = csr_wdata;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enabled      <= 1'b0;
         cfg_ff.scale_num    <= 16'd1;
         cfg_ff.scale_den    <= 16'd1;
         cfg_ff.min_valid_mv <= 16'd0;
         cfg_ff.max_valid_mv <= 16'd65535;
         cfg_ff.empty_mv     <= 16'd3300;
         cfg_ff.full_mv      <= 16'd4200;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Accept samples and build burst totals
   bvm_front #(
      .SAMPLES_PER_READING (SAMPLES_PER_READING)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .queue_full (queue_full),
      .push       (push),
      .push_job   (push_job)
   );

   // Decouple front and back
   bvm_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .full     (queue_full),
      .empty    (queue_empty)
   );

   // Compute one reading per burst total
   bvm_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .head_job       (head_job),
      .queue_empty    (queue_empty),
      .pop            (pop),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_status     (rsp_status),
      .rsp_battery_mv (rsp_battery_mv),
      .rsp_percent    (rsp_percent)
   );

   assign rsp_tdata = {6'd0, rsp_percent, rsp_battery_mv, rsp_status};

endmodule

`default_nettype wire

// ===== bench/battery_voltage_monitor_core_tb.sv =====
// Self-checking bench for the battery voltage monitor: burst averaging, scaling, window and percent.
`default_nettype none

module battery_voltage_monitor_core_tb;
   import bvm_pkg::*;

   localparam int BURST_LEN    = 8;       // samples per reading in the instance below
   localparam int DRAIN_CYCLES = 120;     // back-end settle time after the last owed reading
   localparam int LONG_HOLD    = 1500;    // receiver hold-off that fills the queue
   localparam int CYCLE_LIMIT  = 400000;
   localparam int RAND_PHASES  = 12;
   localparam int MAX_PRINTS   = 50;

   // one expected reading, fields as the result stream carries them
   typedef struct packed {
      status_type             status;
      logic [MV_W-1:0]        batt_mv;
      logic [PCT_W-1:0]       pct;
   } reading_type;

   // Holds the burst accumulator, the register copy and the readings still owed.
   class reading_scoreboard;
      logic                enabled_q;
      logic [MV_W-1:0]     mult;
      logic [MV_W-1:0]     divisor;
      logic [MV_W-1:0]     win_lo;
      logic [MV_W-1:0]     win_hi;
      logic [MV_W-1:0]     zero_pct_mv;
      logic [MV_W-1:0]     full_pct_mv;
      logic [MV_W-1:0]     pin_sum;
      logic [COUNT_W-1:0]  pin_count;
      int                  burst_pos;
      reading_type         owed_readings[$];
      int                  errors;
      int                  checked;
      int                  status_seen[4];

      function new();
         enabled_q   = 1'b0;
         mult        = 16'd1;
         divisor     = 16'd1;
         win_lo      = 16'd0;
         win_hi      = 16'hFFFF;
         zero_pct_mv = 16'd3300;
         full_pct_mv = 16'd4200;
         pin_sum     = '0;
         pin_count   = '0;
         burst_pos   = 0;
         errors      = 0;
         checked     = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [MV_W-1:0] value);
         case (idx)
            CSR_ENABLED:      enabled_q   = value[0];
            CSR_SCALE_NUM:    mult        = value;
            CSR_SCALE_DEN:    divisor     = value;
            CSR_MIN_VALID_MV: win_lo      = value;
            CSR_MAX_VALID_MV: win_hi      = value;
            CSR_EMPTY_MV:     zero_pct_mv = value;
            CSR_FULL_MV:      full_pct_mv = value;
            default: ;
         endcase
      endfunction

      function logic [PCT_W-1:0] charge_pct(longint unsigned mv);
         if (full_pct_mv <= zero_pct_mv) return PCT_NONE;
         if (mv <= zero_pct_mv) return PCT_EMPTY;
         if (mv >= full_pct_mv) return PCT_FULL;
         return PCT_W'(((mv - zero_pct_mv) * 100) / (full_pct_mv - zero_pct_mv));
      endfunction

      // Fold one accepted sample into the burst; owe a reading at the burst end.
      function void take_sample(logic [SAMPLE_W-1:0] mv, logic [SAMPLE_W-1:0] raw,
                                logic failed);
         longint unsigned pin;
         longint unsigned avg;
         longint unsigned scaled;
         logic            counts;
         reading_type     r;
         pin    = mv;
         counts = 1'b1;
         if (mv == 0) begin
            if (failed) counts = 1'b0;
            else pin = (longint'(raw) * 3300) / 4095;
         end
         if (counts && pin != 0) begin
            pin_sum   = pin_sum + MV_W'(pin);
            pin_count = pin_count + COUNT_W'(1);
         end
         if (burst_pos + 1 < BURST_LEN) begin
            burst_pos++;
            return;
         end
         r.batt_mv = '0;
         r.pct     = PCT_NONE;
         if (!enabled_q) r.status = ST_DISABLED;
         else if (pin_count == 0) r.status = ST_NO_SAMPLES;
         else if (divisor == 0) r.status = ST_BAD;
         else begin
            avg    = pin_sum / pin_count;
            scaled = (avg * mult) / divisor;
            if (scaled < win_lo || scaled > win_hi) r.status = ST_BAD;
            else begin
               r.status  = ST_OK;
               r.batt_mv = MV_W'(scaled);
               r.pct     = charge_pct(scaled);
            end
         end
         owed_readings.push_back(r);
         pin_sum   = '0;
         pin_count = '0;
         burst_pos = 0;
      endfunction

      task report(string msg);
         if (errors < MAX_PRINTS) $display("MISMATCH: %s", msg);
         errors++;
      endtask

      task check_reading(logic [RSP_DATA_W-1:0] data);
         reading_type want;
         if (owed_readings.size() == 0) begin
            report($sformatf("reading %h arrived with none owed", data));
            return;
         end
         want = owed_readings.pop_front();
         checked++;
         status_seen[data[1:0]]++;
         if (data[1:0] != want.status)
            report($sformatf("reading %0d status %0d, want %0d",
                             checked, data[1:0], want.status));
         if (data[17:2] != want.batt_mv)
            report($sformatf("reading %0d battery_mv %0d, want %0d",
                             checked, data[17:2], want.batt_mv));
         if (data[25:18] != want.pct)
            report($sformatf("reading %0d percent %0d, want %0d", checked,
                             $signed(data[25:18]), $signed(want.pct)));
         if (data[31:26] != '0)
            report($sformatf("reading %0d fill bits %b not zero", checked, data[31:26]));
      endtask

      function int pending();
         return owed_readings.size();
      endfunction
   endclass

   logic                    clock;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata;   // sample_mv[11:0], raw_code[23:12]
   logic                    req_tuser;   // raw_failed
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [RSP_DATA_W-1:0]   rsp_tdata;   // status[1:0], battery_mv[17:2], percent[25:18]
   logic                    csr_we;
   csr_index_type           csr_addr;
   logic [MV_W-1:0]         csr_wdata;

   reading_scoreboard sb;
   int  cycle_count;
   int  samples_sent;
   int  settings_used;
   int  burst_left;
   bit  no_gaps;
   bit  hold_request;
   int  long_holds;

   battery_voltage_monitor_core #(.SAMPLES_PER_READING(BURST_LEN)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // Watchdog: a hung handshake ends the run here.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles", cycle_count);
      $display("battery_voltage_monitor_core verification failed");
      $finish;
   end

   // Offer one sample and hold it until the transfer. The sender runs in bursts of
   // random length; between bursts drop valid for a random gap, or none at all.
   task automatic send_sample(logic [SAMPLE_W-1:0] mv, logic [SAMPLE_W-1:0] raw,
                              logic failed);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {raw, mv};
      req_tuser  <= failed;
      do @(posedge clock); while (!req_tready);
      sb.take_sample(mv, raw, failed);
      samples_sent++;
   endtask

   // Random sample: mostly real millivolts, often the fallback path, some extremes.
   // A dead burst sends only failed fallbacks so that no sample counts.
   task automatic send_random_sample(bit dead);
      logic [SAMPLE_W-1:0] mv;
      logic [SAMPLE_W-1:0] raw;
      logic                failed;
      raw    = SAMPLE_W'($urandom_range(0, 4095));
      failed = ($urandom_range(0, 1) != 0);
      case ($urandom_range(0, 9))
         0:       mv = ($urandom_range(0, 1) != 0) ? 12'hFFF : 12'd1;
         1, 2, 3: mv = '0;
         default: mv = SAMPLE_W'($urandom_range(1, 4095));
      endcase
      if (mv == 0 && $urandom_range(0, 5) == 0)
         raw = ($urandom_range(0, 1) != 0) ? 12'hFFF : 12'd0;
      if (dead) begin
         mv     = '0;
         failed = 1'b1;
      end
      send_sample(mv, raw, failed);
   endtask

   // Let every owed reading come back, then give the back end time to settle.
   task automatic wait_quiet();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write all seven registers back to back; the block is idle here.
   task automatic load_settings(logic en, logic [MV_W-1:0] num, logic [MV_W-1:0] den,
                                logic [MV_W-1:0] lo, logic [MV_W-1:0] hi,
                                logic [MV_W-1:0] empty_v, logic [MV_W-1:0] full_v);
      logic [MV_W-1:0] vals[7];
      csr_index_type   idx;
      vals = '{{15'd0, en}, num, den, lo, hi, empty_v, full_v};
      idx  = CSR_ENABLED;
      for (int i = 0; i < 7; i++) begin
         csr_we    <= 1'b1;
         csr_addr  <= idx;
         csr_wdata <= vals[i];
         @(posedge clock);
         sb.write_reg(idx, vals[i]);
         idx = idx.next();
      end
      csr_we <= 1'b0;
      settings_used++;
   endtask

   function automatic logic [MV_W-1:0] pick_edge_or(logic [MV_W-1:0] typical);
      case ($urandom_range(0, 7))
         0:       return 16'd0;
         1:       return 16'hFFFF;
         2:       return MV_W'($urandom_range(0, 65535));
         default: return typical;
      endcase
   endfunction

   // Receiver: check each transfer, then stall on its own run/stall pattern.
   // A hold request makes it refuse results without a break for the LONG_HOLD hold-off.
   initial begin
      int rdy_run;
      int stall_run;
      int hold_left;
      rdy_run   = 0;
      stall_run = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) sb.check_reading(rsp_tdata);
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = LONG_HOLD - 1;
            long_holds++;
            rsp_tready <= 1'b0;
         end else if (stall_run > 0) begin
            stall_run--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (rdy_run > 0) rdy_run--;
            else begin
               rdy_run   = $urandom_range(0, 40);
               stall_run = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
         end
      end
   end

   // Main sequence: directed bursts, then random phases under changing settings.
   initial begin
      int n_items;
      bit dead;
      logic [MV_W-1:0] lo_v;
      sb            = new();
      samples_sent  = 0;
      settings_used = 0;
      burst_left    = 0;
      no_gaps       = 1'b0;
      hold_request  = 1'b0;
      long_holds    = 0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= 1'b0;
      rsp_tready <= 1'b0;
      csr_we     <= 1'b0;
      csr_addr   <= CSR_ENABLED;
      csr_wdata  <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Register defaults leave the monitor disabled: burst reports disabled.
      send_sample(12'hFFF, 12'h000, 1'b0);
      send_sample(12'd1,   12'hFFF, 1'b1);
      send_sample(12'd0,   12'hFFF, 1'b0);
      send_sample(12'd0,   12'd0,   1'b0);
      send_sample(12'd0,   12'hFFF, 1'b1);
      send_sample(12'h800, 12'h800, 1'b0);
      send_sample(12'd0,   12'd1,   1'b0);
      send_sample(12'hFFF, 12'hFFF, 1'b1);
      wait_quiet();

      load_settings(1'b1, 16'd1, 16'd1, 16'd0, 16'hFFFF, 16'd3300, 16'd4200);
      // Fallback path: full-scale raw, a raw that truncates to zero, a failed
      // raw that is skipped, and plain millivolts at both ends.
      send_sample(12'd0,   12'hFFF, 1'b0);
      send_sample(12'd0,   12'h800, 1'b0);
      send_sample(12'd0,   12'd1,   1'b0);
      send_sample(12'd0,   12'h555, 1'b1);
      send_sample(12'hFFF, 12'h0AA, 1'b1);
      send_sample(12'd1,   12'd0,   1'b0);
      send_sample(12'd3000, 12'hFFF, 1'b0);
      send_sample(12'd0,   12'd0,   1'b0);
      // Every sample a failed fallback: no valid samples in the burst.
      for (int i = 0; i < BURST_LEN; i++) send_sample(12'd0, 12'($urandom_range(0, 4095)), 1'b1);
      wait_quiet();

      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         case (ph)
            // large scale factor: results overflow the window
            0: load_settings(1'b1, 16'hFFFF, 16'd1, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
            // zero divisor
            1: load_settings(1'b1, 16'd1, 16'd0, 16'd0, 16'hFFFF, 16'd3300, 16'd4200);
            // disabled with an otherwise usable setup
            2: load_settings(1'b0, 16'd2, 16'd1, 16'd0, 16'hFFFF, 16'd3300, 16'd4200);
            // typical divider; receiver backs up here
            3: load_settings(1'b1, 16'd3, 16'd2, 16'd0, 16'hFFFF, 16'd3300, 16'd4200);
            // tiny results, percent range inverted
            4: load_settings(1'b1, 16'd1, 16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0);
            // zero numerator, window pinned at zero
            5: load_settings(1'b1, 16'd0, 16'd7, 16'd0, 16'd0, 16'd0, 16'd1);
            // window pinned at the top
            6: load_settings(1'b1, 16'hFFFF, 16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFE, 16'hFFFF);
            default: begin
               lo_v = pick_edge_or(MV_W'($urandom_range(0, 2000)));
               load_settings($urandom_range(0, 7) != 0,
                             pick_edge_or(MV_W'($urandom_range(1, 8))),
                             pick_edge_or(MV_W'($urandom_range(1, 8))),
                             lo_v,
                             pick_edge_or(MV_W'($urandom_range(3000, 40000))),
                             pick_edge_or(MV_W'($urandom_range(0, 6000))),
                             pick_edge_or(MV_W'($urandom_range(0, 12000))));
            end
         endcase

         n_items = $urandom_range(64, 96);
         if (ph == 3) begin
            // keep offering while the receiver is held off so the queue fills
            no_gaps      = 1'b1;
            hold_request = 1'b1;
            n_items      = 96;
         end
         dead = 1'b0;
         for (int i = 0; i < n_items; i++) begin
            if (sb.burst_pos == 0) dead = ($urandom_range(0, 9) == 0);
            send_random_sample(dead);
         end
         no_gaps = 1'b0;
         wait_quiet();
      end

      $display("Covered %0d samples under %0d register settings, %0d long receiver hold",
               samples_sent, settings_used, long_holds);
      $display("Readings checked %0d: ok %0d, disabled %0d, no samples %0d, rejected %0d",
               sb.checked, sb.status_seen[ST_OK], sb.status_seen[ST_DISABLED],
               sb.status_seen[ST_NO_SAMPLES], sb.status_seen[ST_BAD]);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("battery_voltage_monitor_core verification clean");
      else
         $display("battery_voltage_monitor_core verification failed");
      $finish;
   end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/bvm_pkg.sv
rtl/bvm_front.sv
rtl/bvm_queue.sv
rtl/bvm_div.sv
rtl/bvm_back.sv
rtl/battery_voltage_monitor_core.sv
bench/battery_voltage_monitor_core_tb.sv
